### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the pan tracker datapath
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SPT_ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define SPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// types, constants and control structs of the servo pan tracker
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int X_BITS          = 10;
    localparam int ANGLE_FRAC_BITS = 8;

    localparam int CLS_W   = 8;
    localparam int STEP_W  = 13;
    localparam int PULSE_W = 12;
    localparam int PAN_W   = 16;

    localparam int ANGLE_MAX   = 180 << ANGLE_FRAC_BITS;
    localparam int ANGLE_INIT  = 90 << ANGLE_FRAC_BITS;
    localparam int ANG_W       = $clog2(ANGLE_MAX + 1);
    localparam int STEP_MAX    = (1 << STEP_W) - 1;
    localparam int NO_TARGET   = 999;
    localparam int PULSE_MIN   = 500;
    localparam int PULSE_MAX   = 2600;
    localparam int PULSE_SPAN  = 2100;

    // pulse span over 180 degrees is 2100 / 180 = 35 / 3; the divide by 3
    // is a reciprocal multiply, exact for operands below 2^17
    localparam int PULSE_NUM   = PULSE_SPAN / 60;
    localparam int PNUM_W      = $clog2(PULSE_NUM + 1);
    localparam int PM_W        = $clog2(180 * PULSE_NUM + 1);
    localparam int DIV3_SH     = 17;
    localparam int DIV3_MUL    = ((1 << DIV3_SH) + 2) / 3;

    // divider sizing for the step map
    localparam int DIVD_W = X_BITS + STEP_W;
    localparam int DVSR_W = X_BITS;
    localparam int CNT_W  = $clog2(DIVD_W + 1);

    // configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = STEP_W;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_EDGE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIG_STEP    = 3'd4;

    localparam int FRAME_WIDTH_RST = 640;
    localparam int LEFT_EDGE_RST   = 280;
    localparam int RIGHT_EDGE_RST  = 360;
    localparam int SMALL_STEP_RST  = 256;
    localparam int BIG_STEP_RST    = 1280;

    // side on which the target was last seen
    localparam logic [1:0] SIDE_NONE   = 2'd0;
    localparam logic [1:0] SIDE_LEFT   = 2'd1;
    localparam logic [1:0] SIDE_CENTRE = 2'd2;
    localparam logic [1:0] SIDE_RIGHT  = 2'd3;

    typedef logic [X_BITS-1:0]     x_t;
    typedef logic [CLS_W-1:0]      cls_t;
    typedef logic [STEP_W-1:0]     step_t;
    typedef logic [ANG_W-1:0]      ang_t;
    typedef logic [PULSE_W-1:0]    pulse_t;
    typedef logic [PAN_W-1:0]      pan_t;
    typedef logic [PM_W-1:0]       pm_t;
    typedef logic [DIVD_W-1:0]     divd_t;
    typedef logic [DVSR_W-1:0]     dvsr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef struct packed {
        logic load_in;
        logic step_setup;
        logic step_finish;
        logic angle_upd;
        logic pulse_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage

### sv/spt_if.sv
// ----------------------------------------------------------------------------
// spt_if
// valid/ready channels of the servo pan tracker
// ----------------------------------------------------------------------------
interface spt_report_if;
    logic              valid;
    logic              ready;
    spt_pkg::x_t       target_x;
    spt_pkg::cls_t     target_class;

    modport source (output valid, output target_x, output target_class, input ready);
    modport sink (input valid, input target_x, input target_class, output ready);
endinterface

interface spt_result_if;
    logic              valid;
    logic              ready;
    spt_pkg::pulse_t   pulse_width_us;
    spt_pkg::pan_t     pan_angle;

    modport source (output valid, output pulse_width_us, output pan_angle, input ready);
    modport sink (input valid, input pulse_width_us, input pan_angle, output ready);
endinterface

interface spt_cfg_if;
    logic               valid;
    logic               ready;
    spt_pkg::cfg_idx_t  index;
    spt_pkg::cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/spt_div.sv
// ----------------------------------------------------------------------------
// spt_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module spt_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  spt_pkg::divd_t  dividend,
    input  spt_pkg::dvsr_t  divisor,
    output logic            busy,
    output spt_pkg::divd_t  quotient
);

    logic                   busy_reg, busy_next;
    spt_pkg::cnt_t          cnt_reg, cnt_next;
    spt_pkg::dvsr_t         rem_reg, rem_next;
    spt_pkg::divd_t         quo_reg, quo_next;
    spt_pkg::dvsr_t         dvsr_reg, dvsr_next;
    logic [spt_pkg::DVSR_W:0] trial;
    logic                   fits;

    assign trial = {rem_reg, quo_reg[spt_pkg::DIVD_W-1]};
    assign fits  = (trial >= {1'b0, dvsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = spt_pkg::cnt_t'(spt_pkg::DIVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvsr_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? spt_pkg::dvsr_t'(trial - {1'b0, dvsr_reg})
                            : trial[spt_pkg::DVSR_W-1:0];
            quo_next = {quo_reg[spt_pkg::DIVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == spt_pkg::cnt_t'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### sv/spt_dp.sv
// ----------------------------------------------------------------------------
// spt_dp
// datapath: config registers, step map, angle update, pulse map, output reg
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spt_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  spt_pkg::cmd_t   cmd,
    output spt_pkg::sts_t   sts,
    input  spt_pkg::x_t     x_in,
    input  spt_pkg::cls_t   cls_in,
    spt_cfg_if.sink         cfg,
    spt_result_if.source    result
);

    localparam int SUM_W = spt_pkg::DIVD_W + 2;
    localparam int AS_W  = spt_pkg::ANG_W + 2;
    localparam int PN_W  = spt_pkg::ANG_W + spt_pkg::PNUM_W;
    localparam int PR_W  = spt_pkg::PM_W + spt_pkg::DIV3_SH;

    // configuration
    spt_pkg::x_t    fw_reg, le_reg, re_reg;
    spt_pkg::step_t small_reg, big_reg;

    // tracker state
    spt_pkg::ang_t  angle_reg, angle_next;
    spt_pkg::step_t step_reg, step_next;
    logic [1:0]     side_reg, side_next;
    logic           div_used_reg, div_used_next;

    // per request
    spt_pkg::x_t    x_reg;
    spt_pkg::cls_t  cls_reg;
    logic           neg_reg;

    // output register
    logic           out_valid_reg, out_valid_next;
    spt_pkg::pulse_t pulse_reg;
    spt_pkg::pan_t  pan_reg;

    // step map
    spt_pkg::x_t    centre, x_dist, den_l, den_r;
    logic           left_side, in_frame, need_div, diff_neg, no_target, moves;
    logic signed [spt_pkg::STEP_W:0] diff;
    spt_pkg::step_t diff_mag;
    spt_pkg::divd_t step_prod;
    logic signed [SUM_W-1:0] q_signed, step_sum;
    spt_pkg::step_t step_sat;

    // angle update
    spt_pkg::step_t eff_step;
    logic signed [AS_W-1:0] ang_sum;
    spt_pkg::ang_t  ang_clamped;

    // pulse map
    spt_pkg::ang_t  ang_rest;
    logic [PN_W-1:0] pulse_num;
    spt_pkg::pm_t   pm_reg;
    logic [PR_W-1:0] pulse_recip;
    spt_pkg::pulse_t pulse_quo;

    // divider
    logic           div_start, div_busy;
    spt_pkg::divd_t div_dividend, div_quo;
    spt_pkg::dvsr_t div_divisor;

    assign centre    = fw_reg >> 1;
    assign left_side = (x_reg < centre);
    assign in_frame  = (x_reg <= fw_reg);
    assign den_l     = centre - 1'b1;
    assign den_r     = fw_reg - centre;
    assign x_dist    = left_side ? (centre - x_reg) : (x_reg - centre);
    assign need_div  = left_side ? (centre != spt_pkg::x_t'(1))
                                 : (in_frame && (den_r != '0));

    assign diff      = $signed({1'b0, big_reg}) - $signed({1'b0, small_reg});
    assign diff_neg  = diff[spt_pkg::STEP_W];
    assign diff_mag  = spt_pkg::step_t'(diff_neg ? -diff : diff);
    assign step_prod = spt_pkg::divd_t'(x_dist) * spt_pkg::divd_t'(diff_mag);

    // quotient truncates toward zero, so the sign is applied after dividing
    assign q_signed  = neg_reg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    assign step_sum  = $signed({{(SUM_W - spt_pkg::STEP_W){1'b0}}, small_reg}) + q_signed;

    always_comb
    begin
        if (step_sum < 0)
            step_sat = '0;
        else if (step_sum > SUM_W'(spt_pkg::STEP_MAX))
            step_sat = spt_pkg::step_t'(spt_pkg::STEP_MAX);
        else
            step_sat = step_sum[spt_pkg::STEP_W-1:0];
    end

    assign no_target = (x_reg == spt_pkg::x_t'(spt_pkg::NO_TARGET));
    assign moves     = (cls_reg inside {[8'd1:8'd4]});
    assign eff_step  = no_target ? big_reg : step_reg;

    always_comb
    begin
        side_next = side_reg;
        ang_sum   = $signed({2'b00, angle_reg});
        if (no_target)
        begin
            if (side_reg == spt_pkg::SIDE_LEFT)
                ang_sum = $signed({2'b00, angle_reg}) - $signed(AS_W'(eff_step));
            else
                ang_sum = $signed({2'b00, angle_reg}) + $signed(AS_W'(eff_step));
        end
        else if (x_reg < le_reg)
        begin
            side_next = spt_pkg::SIDE_LEFT;
            if (moves)
                ang_sum = $signed({2'b00, angle_reg}) - $signed(AS_W'(eff_step));
        end
        else if (x_reg < re_reg)
        begin
            side_next = spt_pkg::SIDE_CENTRE;
        end
        else
        begin
            side_next = spt_pkg::SIDE_RIGHT;
            if (moves)
                ang_sum = $signed({2'b00, angle_reg}) + $signed(AS_W'(eff_step));
        end
    end

    always_comb
    begin
        if (ang_sum < 0)
            ang_clamped = '0;
        else if (ang_sum > AS_W'(spt_pkg::ANGLE_MAX))
            ang_clamped = spt_pkg::ang_t'(spt_pkg::ANGLE_MAX);
        else
            ang_clamped = ang_sum[spt_pkg::ANG_W-1:0];
    end

    // (rest * 35) >> frac bits is registered in pm_reg first, then divided by 3 from that register
    assign ang_rest    = spt_pkg::ang_t'(spt_pkg::ANGLE_MAX) - angle_reg;
    assign pulse_num   = PN_W'(ang_rest) * PN_W'(spt_pkg::PULSE_NUM);
    assign pulse_recip = PR_W'(pm_reg) * PR_W'(spt_pkg::DIV3_MUL);
    assign pulse_quo   = spt_pkg::pulse_t'(pulse_recip[PR_W-1:spt_pkg::DIV3_SH]);

    assign div_start    = cmd.step_setup && need_div;
    assign div_dividend = step_prod;
    assign div_divisor  = spt_pkg::dvsr_t'(left_side ? den_l : den_r);

    spt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_comb
    begin
        step_next     = step_reg;
        angle_next    = angle_reg;
        div_used_next = div_used_reg;
        if (cmd.step_setup)
        begin
            div_used_next = need_div;
            if (left_side && !need_div)
                step_next = big_reg;
            else if (!left_side && in_frame && !need_div)
                step_next = small_reg;
        end
        if (cmd.step_finish && div_used_reg)
            step_next = step_sat;
        if (cmd.angle_upd)
        begin
            angle_next = ang_clamped;
            if (no_target)
                step_next = big_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.valid && result.ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg        <= spt_pkg::x_t'(spt_pkg::FRAME_WIDTH_RST);
            le_reg        <= spt_pkg::x_t'(spt_pkg::LEFT_EDGE_RST);
            re_reg        <= spt_pkg::x_t'(spt_pkg::RIGHT_EDGE_RST);
            small_reg     <= spt_pkg::step_t'(spt_pkg::SMALL_STEP_RST);
            big_reg       <= spt_pkg::step_t'(spt_pkg::BIG_STEP_RST);
            angle_reg     <= spt_pkg::ang_t'(spt_pkg::ANGLE_INIT);
            step_reg      <= '0;
            side_reg      <= spt_pkg::SIDE_NONE;
            div_used_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    spt_pkg::REG_FRAME_WIDTH: fw_reg    <= spt_pkg::x_t'(cfg.data);
                    spt_pkg::REG_LEFT_EDGE:   le_reg    <= spt_pkg::x_t'(cfg.data);
                    spt_pkg::REG_RIGHT_EDGE:  re_reg    <= spt_pkg::x_t'(cfg.data);
                    spt_pkg::REG_SMALL_STEP:  small_reg <= spt_pkg::step_t'(cfg.data);
                    spt_pkg::REG_BIG_STEP:    big_reg   <= spt_pkg::step_t'(cfg.data);
                    default: ;
                endcase
            end
            angle_reg     <= angle_next;
            step_reg      <= step_next;
            if (cmd.angle_upd)
                side_reg  <= side_next;
            div_used_reg  <= div_used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg   <= x_in;
            cls_reg <= cls_in;
        end
        if (cmd.step_setup)
            neg_reg <= diff_neg;
        if (cmd.pulse_start)
            pm_reg <= spt_pkg::pm_t'(pulse_num >> spt_pkg::ANGLE_FRAC_BITS);
        if (cmd.out_load)
        begin
            pulse_reg <= spt_pkg::pulse_t'(spt_pkg::PULSE_MIN) + pulse_quo;
            pan_reg   <= spt_pkg::pan_t'(angle_reg);
        end
    end

    assign cfg.ready             = 1'b1;
    assign result.valid          = out_valid_reg;
    assign result.pulse_width_us = pulse_reg;
    assign result.pan_angle      = pan_reg;

    assign sts.div_busy = div_busy;
    assign sts.out_free = !out_valid_reg || result.ready;

    `SPT_ASSERT_HOLDS(a_angle_range, clk, rst_n,
        angle_reg <= spt_pkg::ang_t'(spt_pkg::ANGLE_MAX), "pan angle above 180 degrees")
    `SPT_ASSERT_HOLDS(a_pulse_range, clk, rst_n,
        !out_valid_reg ||
        (pulse_reg >= spt_pkg::pulse_t'(spt_pkg::PULSE_MIN) &&
         pulse_reg <= spt_pkg::pulse_t'(spt_pkg::PULSE_MAX)),
        "servo pulse out of range")
    `SPT_ASSERT_NEXT(a_step_div_start, clk, rst_n,
        cmd.step_setup && need_div, div_busy, "step map did not start the divider")

endmodule

### sv/spt_ctrl.sv
// ----------------------------------------------------------------------------
// spt_ctrl
// sequencer for one camera report: step map, angle update, pulse map
// ----------------------------------------------------------------------------
module spt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    spt_report_if.sink      report,
    input  spt_pkg::sts_t   sts,
    output spt_pkg::cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SETUP     = 3'd1;
    localparam logic [2:0] ST_STEP_DIV  = 3'd2;
    localparam logic [2:0] ST_ANGLE     = 3'd3;
    localparam logic [2:0] ST_PULSE     = 3'd4;
    localparam logic [2:0] ST_PULSE_DIV = 3'd5;

    logic [2:0] state_reg, state_next;

    assign report.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (report.valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.step_setup = 1'b1;
                state_next     = ST_STEP_DIV;
            end
            ST_STEP_DIV:
            begin
                if (!sts.div_busy)
                begin
                    cmd.step_finish = 1'b1;
                    state_next      = ST_ANGLE;
                end
            end
            ST_ANGLE:
            begin
                cmd.angle_upd = 1'b1;
                state_next    = ST_PULSE;
            end
            ST_PULSE:
            begin
                cmd.pulse_start = 1'b1;
                state_next      = ST_PULSE_DIV;
            end
            ST_PULSE_DIV:
            begin
                // hold the pulse map until the output register frees up
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### sv/servo_pan_tracker.sv
// ----------------------------------------------------------------------------
// servo_pan_tracker
// pan servo control from camera target reports
// ----------------------------------------------------------------------------
// usage:
//   report: one camera report per request (target_x, 999 = no target, and
//     target_class); valid/ready, taken when both are high.
//   result: one request per report with pulse_width_us and pan_angle,
//     held in an output register until the receiver takes it.
//   cfg: register writes by index (frame_width, left_edge, right_edge,
//     small_step, big_step); always ready, write only while idle.
// sequence: one report at a time. the step map waits for the bit-serial
//   divider, which a report that needs no division does not start; the
//   pulse map is a reciprocal multiply, registered between the multiply
//   by 35 and the divide by 3.
// reset: angle 90 degrees, step zero, no side seen, config at defaults,
//   no result pending.
// stall: the next report is taken while a result waits; its own result
//   is held in the datapath until the output register is free.
// ----------------------------------------------------------------------------
module servo_pan_tracker (
    input  logic         clk,
    input  logic         rst_n,
    spt_report_if.sink   report,
    spt_result_if.source result,
    spt_cfg_if.sink      cfg
);

    spt_pkg::cmd_t cmd;
    spt_pkg::sts_t sts;

    spt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .report (report),
        .sts    (sts),
        .cmd    (cmd)
    );

    spt_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .x_in   (report.target_x),
        .cls_in (report.target_class),
        .cfg    (cfg),
        .result (result)
    );

endmodule

### test/servo_pan_tracker_tb.sv
// ----------------------------------------------------------------------------
// servo_pan_tracker_tb
// self-checking bench for the camera driven pan servo controller
// ----------------------------------------------------------------------------
// camera reports go in through a queue-fed driver and servo commands are
// checked by a monitor against a cycle-free tracker model kept in the bench.
// a directed opening covers search, band edges, class gating and angle
// limits; then register settings change phase by phase (degenerate frames,
// crossed band, inverted and saturating step maps, unused indexes) with
// random reports and random stalls on both sides.
// ----------------------------------------------------------------------------
module servo_pan_tracker_tb;
    import spt_pkg::*;

    localparam cfg_idx_t REG_SPARE_LO = 3'd5;
    localparam cfg_idx_t REG_SPARE_HI = 3'd7;
    localparam int PHASES = 12;
    localparam int PHASE_REPORTS = 100;

    typedef struct {
        x_t   x;
        cls_t cls;
    } report_t;

    typedef struct {
        pulse_t pulse;
        pan_t   pan;
    } servo_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    spt_report_if report_bus ();
    spt_result_if result_bus ();
    spt_cfg_if    cfg_bus ();

    servo_pan_tracker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .report (report_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always #1 clk = ~clk;

    // register copies
    int cfg_frame_w = FRAME_WIDTH_RST;
    int cfg_left    = LEFT_EDGE_RST;
    int cfg_right   = RIGHT_EDGE_RST;
    int cfg_small   = SMALL_STEP_RST;
    int cfg_big     = BIG_STEP_RST;

    // tracker state
    int         trk_angle = ANGLE_INIT;
    int         trk_step  = 0;
    logic [1:0] trk_side  = SIDE_NONE;

    report_t    report_fifo[$];
    servo_cmd_t servo_cmds[$];
    report_t    next_report;
    servo_cmd_t head_cmd;

    int reports_queued = 0;
    int reports_taken  = 0;
    int error_count    = 0;
    int send_gap       = 0;
    int take_gap       = 0;
    bit no_idle        = 1'b0;

    task automatic flag_mismatch(input string what);
        error_count++;
        $display("tb: mismatch: %s", what);
    endtask

    function automatic int clip_step(input int v);
        if (v < 0)
            return 0;
        if (v > STEP_MAX)
            return STEP_MAX;
        return v;
    endfunction

    // advance the tracker by one accepted report and queue the servo command
    task automatic track_report(input x_t x, input cls_t cls);
        int c;
        int xs;
        int diff;
        int den;
        int pulse;
        bit moves;
        servo_cmd_t cmd;
        moves = (cls >= 1 && cls <= 4);
        c = cfg_frame_w / 2;
        xs = x;
        diff = cfg_big - cfg_small;
        if (xs < c)
        begin
            den = c - 1;
            if (den <= 0)
                trk_step = clip_step(cfg_big);
            else
                trk_step = clip_step(cfg_small + ((c - xs) * diff) / den);
        end
        else if (xs <= cfg_frame_w)
        begin
            den = cfg_frame_w - c;
            if (den <= 0)
                trk_step = clip_step(cfg_small);
            else
                trk_step = clip_step(cfg_small + ((xs - c) * diff) / den);
        end
        // beyond the frame the step is left as it was
        if (xs == NO_TARGET)
        begin
            trk_step = cfg_big;
            if (trk_side == SIDE_LEFT)
                trk_angle -= trk_step;
            else
                trk_angle += trk_step;
        end
        else if (xs < cfg_left)
        begin
            if (moves)
                trk_angle -= trk_step;
            trk_side = SIDE_LEFT;
        end
        else if (xs < cfg_right)
        begin
            trk_side = SIDE_CENTRE;
        end
        else
        begin
            if (moves)
                trk_angle += trk_step;
            trk_side = SIDE_RIGHT;
        end
        if (trk_angle > ANGLE_MAX)
            trk_angle = ANGLE_MAX;
        else if (trk_angle < 0)
            trk_angle = 0;
        pulse = PULSE_MIN + ((ANGLE_MAX - trk_angle) * PULSE_SPAN) / ANGLE_MAX;
        cmd.pulse = pulse_t'(pulse);
        cmd.pan = pan_t'(trk_angle);
        servo_cmds.push_back(cmd);
    endtask

    // report driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (report_bus.valid && report_bus.ready)
            begin
                track_report(report_bus.target_x, report_bus.target_class);
                reports_taken++;
            end
            // a request not yet taken stays on the bus
            if (!(report_bus.valid && !report_bus.ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    report_bus.valid <= 1'b0;
                end
                else if (report_fifo.size() > 0)
                begin
                    next_report = report_fifo.pop_front();
                    report_bus.valid <= 1'b1;
                    report_bus.target_x <= next_report.x;
                    report_bus.target_class <= next_report.cls;
                    send_gap = no_idle ? 0 : $urandom_range(0, 4);
                end
                else
                begin
                    report_bus.valid <= 1'b0;
                end
            end
        end
    end

    // servo command monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (servo_cmds.size() == 0)
                begin
                    flag_mismatch($sformatf("result with nothing pending: pulse %0d angle %0d",
                                            result_bus.pulse_width_us, result_bus.pan_angle));
                end
                else
                begin
                    head_cmd = servo_cmds.pop_front();
                    if (result_bus.pulse_width_us !== head_cmd.pulse)
                        flag_mismatch($sformatf("pulse_width_us got %0d want %0d",
                                                result_bus.pulse_width_us, head_cmd.pulse));
                    if (result_bus.pan_angle !== head_cmd.pan)
                        flag_mismatch($sformatf("pan_angle got %0d want %0d",
                                                result_bus.pan_angle, head_cmd.pan));
                end
                take_gap = no_idle ? 0 : $urandom_range(0, 4);
                result_bus.ready <= (take_gap == 0);
            end
            else if (take_gap > 0)
            begin
                take_gap--;
                result_bus.ready <= (take_gap == 0);
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    task automatic queue_report(input x_t x, input cls_t cls);
        report_t r;
        r.x = x;
        r.cls = cls;
        report_fifo.push_back(r);
        reports_queued++;
    endtask

    // returns at a rising edge once every report is taken and answered
    task automatic wait_settled();
        do
            @(posedge clk);
        while (reports_taken != reports_queued || servo_cmds.size() != 0);
    endtask

    // leaves valid high; the caller lowers it after the last write
    task automatic set_reg(input cfg_idx_t idx, input cfg_data_t val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            REG_FRAME_WIDTH: cfg_frame_w = val[X_BITS-1:0];
            REG_LEFT_EDGE:   cfg_left = val[X_BITS-1:0];
            REG_RIGHT_EDGE:  cfg_right = val[X_BITS-1:0];
            REG_SMALL_STEP:  cfg_small = val;
            REG_BIG_STEP:    cfg_big = val;
            default:         ;
        endcase
    endtask

    task automatic configure(input cfg_data_t fw, input cfg_data_t le, input cfg_data_t re,
                             input cfg_data_t ss, input cfg_data_t bs);
        set_reg(REG_FRAME_WIDTH, fw);
        set_reg(REG_LEFT_EDGE, le);
        set_reg(REG_RIGHT_EDGE, re);
        set_reg(REG_SMALL_STEP, ss);
        set_reg(REG_BIG_STEP, bs);
        cfg_bus.valid <= 1'b0;
    endtask

    initial
    begin
        int fw_val;
        int lo;
        int hi;
        int pick;
        x_t rx;
        cls_t rc;
        report_bus.valid = 1'b0;
        report_bus.target_x = '0;
        report_bus.target_class = '0;
        result_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // default registers: search with no side seen, band edges, class gating
        queue_report(x_t'(NO_TARGET), 8'd0);
        queue_report(10'd0, 8'd1);
        queue_report(10'd1023, 8'd4);
        queue_report(10'd640, 8'd2);
        queue_report(10'd300, 8'd3);
        queue_report(x_t'(NO_TARGET), 8'd255);
        queue_report(10'd100, 8'd5);
        queue_report(x_t'(NO_TARGET), 8'd0);
        queue_report(10'd320, 8'd0);
        queue_report(10'd359, 8'd1);
        queue_report(10'd360, 8'd1);
        queue_report(10'd280, 8'd4);
        queue_report(10'd279, 8'd4);
        queue_report(10'd641, 8'd1);
        wait_settled();

        // widest steps drive the angle into both limits
        configure(13'd640, 13'd280, 13'd360, cfg_data_t'(STEP_MAX), cfg_data_t'(STEP_MAX));
        repeat (3) queue_report(x_t'(NO_TARGET), 8'd0);
        repeat (6) queue_report(10'd0, 8'd1);
        queue_report(x_t'(NO_TARGET), 8'd0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_settled();
            case (phase)
                0: configure(13'd1023, 13'd0, 13'd1023, 13'd0, cfg_data_t'(STEP_MAX));
                1: configure(13'd2, 13'd1, 13'd2, cfg_data_t'(STEP_MAX), 13'd0);
                // frame width of zero through the masked upper bits, crossed band
                2: configure(13'h1C00, 13'h1FFF, 13'd0, 13'd7680, 13'd7680);
                3: configure(13'h0401, 13'd1, 13'd0, 13'd0, 13'd0);
                4:
                begin
                    set_reg(REG_SPARE_LO, cfg_data_t'($urandom_range(0, STEP_MAX)));
                    set_reg(REG_SPARE_HI, cfg_data_t'(STEP_MAX));
                    configure(13'd6, 13'd2, 13'd4, 13'd0, cfg_data_t'(STEP_MAX));
                end
                5: configure(13'd6, 13'd3, 13'd3, cfg_data_t'(STEP_MAX), 13'd0);
                default:
                begin
                    fw_val = $urandom_range(2, 1023);
                    lo = $urandom_range(0, fw_val);
                    hi = $urandom_range(lo, fw_val);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        pick = lo;
                        lo = hi;
                        hi = pick;
                    end
                    configure(cfg_data_t'(fw_val | ($urandom_range(0, 7) << X_BITS)),
                              cfg_data_t'(lo | ($urandom_range(0, 7) << X_BITS)),
                              cfg_data_t'(hi | ($urandom_range(0, 7) << X_BITS)),
                              cfg_data_t'($urandom_range(0, STEP_MAX)),
                              cfg_data_t'($urandom_range(0, STEP_MAX)));
                end
            endcase
            no_idle = (phase % 4 == 3);
            for (int i = 0; i < PHASE_REPORTS; i++)
            begin
                // halfway through, hold the reports until every command is back
                if (i == PHASE_REPORTS / 2)
                    wait_settled();
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    rx = x_t'(NO_TARGET);
                else if (pick < 24)
                    rx = x_t'($urandom_range(0, 1023));
                else
                    rx = x_t'($urandom_range(0, cfg_frame_w));
                if ($urandom_range(0, 99) < 60)
                    rc = cls_t'($urandom_range(1, 4));
                else
                    rc = cls_t'($urandom_range(0, 255));
                queue_report(rx, rc);
            end
        end

        wait_settled();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
